>>> hw/rtl/rthsl_pkg.sv
package rthsl_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int LANES = 3;
	// divisors reach 6 * 255, remainders stay below twice the divisor
	localparam int DEN_W = 11;
	localparam int REM_W = 12;

	localparam int LANE_HUE = 0;
	localparam int LANE_SAT = 1;
	localparam int LANE_LIG = 2;

	localparam logic [DEN_W-1:0] LIG_DEN = DEN_W'(510);

	typedef logic [REM_W-1:0] rem_t;
	typedef logic [DEN_W-1:0] den_t;

endpackage

>>> hw/rtl/rthsl_front.sv
module rthsl_front import rthsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       valid_s1,
	output logic       gray_s1,
	output rem_t       rem_s1 [LANES],
	output den_t       den_s1 [LANES]
);

	logic [7:0] mx, mn, d;
	logic [8:0] sum;
	rem_t       hue_num, d12;
	den_t       sat_den;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d   = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		d12 = REM_W'(d);
		sat_den = (sum > 9'd255) ? DEN_W'(10'd510 - {1'b0, sum}) : DEN_W'(sum);
		// sector priority red, green, blue
		if (red == mx) begin
			if (green < blue)
				hue_num = 12'd6 * d12 - REM_W'(blue - green);
			else
				hue_num = REM_W'(green - blue);
		end else if (green == mx) begin
			hue_num = 12'd2 * d12 + REM_W'(blue) - REM_W'(red);
		end else begin
			hue_num = 12'd4 * d12 + REM_W'(red) - REM_W'(green);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_s1          <= (d == 8'd0);
			rem_s1[LANE_HUE] <= hue_num;
			den_s1[LANE_HUE] <= DEN_W'(12'd6 * d12);
			rem_s1[LANE_SAT] <= REM_W'(d);
			den_s1[LANE_SAT] <= sat_den;
			rem_s1[LANE_LIG] <= REM_W'(sum);
			den_s1[LANE_LIG] <= LIG_DEN;
		end
	end

endmodule

>>> hw/rtl/rthsl_cell.sv
module rthsl_cell import rthsl_pkg::*; #(
	parameter int QW = FRACTION_BITS_DEF + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic          gray_in,
	input  rem_t          rem_in  [LANES],
	input  den_t          den_in  [LANES],
	input  logic [QW-1:0] quot_in [LANES],
	output logic          valid_q,
	output logic          gray_q,
	output rem_t          rem_q   [LANES],
	output den_t          den_q   [LANES],
	output logic [QW-1:0] quot_q  [LANES]
);

	// one restoring division step per lane
	logic ge   [LANES];
	rem_t diff [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ge[i]   = rem_in[i] >= REM_W'(den_in[i]);
			diff[i] = ge[i] ? rem_in[i] - REM_W'(den_in[i]) : rem_in[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gray_q <= gray_in;
			for (int i = 0; i < LANES; i++) begin
				rem_q[i]  <= {diff[i][REM_W-2:0], 1'b0};
				den_q[i]  <= den_in[i];
				quot_q[i] <= {quot_in[i][QW-2:0], ge[i]};
			end
		end
	end

endmodule

>>> hw/rtl/rgb_to_hsl_converter.sv
// channel  direction  fields (low bit up)
// s_axis   in         tdata: red[7:0] green[15:8] blue[23:16]
// m_axis   out        tdata: hue[F-1:0] saturation[F+1] lightness[F+1], zero padded
// One pixel per clock sustained while m_axis_tready is high.
// A front stage finds max/min, then FRACTION_BITS + 1 division cells each
// settle one quotient bit of hue, saturation and lightness side by side.
// Reset clears the valid bits only. A stall at m_axis holds the whole chain.
module rgb_to_hsl_converter import rthsl_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // red, green, blue
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [((3*FRACTION_BITS+2+7)/8)*8-1:0] m_axis_tdata // hue, saturation, lightness
);

	localparam int QW  = FRACTION_BITS + 1;
	localparam int NC  = QW;
	localparam int OW  = ((3*FRACTION_BITS+2+7)/8)*8;
	localparam int PAD = OW - (3*FRACTION_BITS+2);

	logic          en;
	logic          v    [NC+1];
	logic          gray [NC+1];
	rem_t          rem  [NC+1][LANES];
	den_t          den  [NC+1][LANES];
	logic [QW-1:0] quot [NC+1][LANES];

	assign en            = !v[NC] || m_axis_tready;
	assign s_axis_tready = en;

	rthsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (s_axis_tvalid),
		.red      (s_axis_tdata[7:0]),
		.green    (s_axis_tdata[15:8]),
		.blue     (s_axis_tdata[23:16]),
		.valid_s1 (v[0]),
		.gray_s1  (gray[0]),
		.rem_s1   (rem[0]),
		.den_s1   (den[0])
	);

	always_comb begin
		for (int i = 0; i < LANES; i++) quot[0][i] = '0;
	end

	for (genvar c = 0; c < NC; c++) begin : g_cell
		rthsl_cell #(.QW(QW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (v[c]),
			.gray_in  (gray[c]),
			.rem_in   (rem[c]),
			.den_in   (den[c]),
			.quot_in  (quot[c]),
			.valid_q  (v[c+1]),
			.gray_q   (gray[c+1]),
			.rem_q    (rem[c+1]),
			.den_q    (den[c+1]),
			.quot_q   (quot[c+1])
		);
	end

	logic [FRACTION_BITS-1:0] hue;
	logic [QW-1:0]            sat;

	// grey pixel: hue and saturation forced to zero
	assign hue = gray[NC] ? '0 : quot[NC][LANE_HUE][FRACTION_BITS-1:0];
	assign sat = gray[NC] ? '0 : quot[NC][LANE_SAT];

	assign m_axis_tvalid = v[NC];
	if (PAD > 0) begin : g_pad
		assign m_axis_tdata = {{PAD{1'b0}}, quot[NC][LANE_LIG], sat, hue};
	end else begin : g_nopad
		assign m_axis_tdata = {quot[NC][LANE_LIG], sat, hue};
	end

endmodule
